### rtl/efahr_pkg.sv
// Shared constants, widths and register codes of the envelope follower.
package efahr_pkg;

  // Sample format: signed Q5.(SampleWidth-5).
  localparam int SampleWidth = 24;
  localparam int SampleFrac  = SampleWidth - 5;
  localparam int HoldWidth   = 20;

  // Magnitude is unsigned Q5.23; the sample fraction is padded or cut to 23 bits.
  localparam int MagW   = 28;
  localparam int MagShl = (SampleFrac < 23) ? (23 - SampleFrac) : 0;
  localparam int MagShr = (SampleFrac >= 23) ? (SampleFrac - 23) : 0;

  // Shared multiplier operands and product.
  localparam int MulAW = 34;
  localparam int MulBW = 28;
  localparam int ProdW = MulAW + MulBW;

  // Datapath widths.
  localparam int MsW       = 34;
  localparam int SqW       = 33;
  localparam int LevelW    = 32;
  localparam int EnvW      = 24;
  localparam int CoeffW    = 24;
  localparam int RmsCoeffW = 25;

  // Square root unit: radicand is mean square shifted up by 22 bits.
  localparam int RootW = 28;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 2;
  localparam int CntW  = $clog2(RootW);

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 25;

  // Fixed-point constants.
  localparam logic [RmsCoeffW-1:0] OneQ24  = RmsCoeffW'(25'h1000000);
  localparam logic [EnvW-1:0]      OneQ23  = EnvW'(24'h800000);
  localparam logic [ProdW-1:0]     HalfQ24 = ProdW'(1) << 23;
  localparam logic [ProdW-1:0]     HalfQ23 = ProdW'(1) << 22;
  localparam logic [ProdW-1:0]     HalfQ22 = ProdW'(1) << 21;

  // Level detection modes; the unused code behaves as peak.
  localparam logic [1:0] ModePeak   = 2'd0;
  localparam logic [1:0] ModeMeanSq = 2'd1;
  localparam logic [1:0] ModeRms    = 2'd2;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DETECT_MODE   = 3'd0,
    CFG_ATTACK_COEFF  = 3'd1,
    CFG_RELEASE_COEFF = 3'd2,
    CFG_HOLD_LENGTH   = 3'd3,
    CFG_RMS_COEFF     = 3'd4
  } cfg_idx_e;

endpackage

### rtl/efahr_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module efahr_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [efahr_pkg::RadW-1:0]     radicand_i,
  output logic                           done_o,
  output logic [efahr_pkg::RootW-1:0]    root_o
);
  import efahr_pkg::*;

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;

  // One restoring step: bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial  = {root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/envelope_follower_attack_hold_release_core.sv
// Envelope follower with peak, mean-square and running RMS detection, attack, hold, release.
//
// One sample is taken per beat on the input channel and gives one envelope beat on the
// output channel. Samples are processed one at a time by a sequencer around a single
// shared 34x28 multiplier; running RMS mode spends most of its time in the 28-step
// bit-serial square root. A finished envelope sits in an output register, so the next
// sample is accepted while it waits; the core only stalls at its final update step when
// that register is still full. The user must write the configuration port only while the
// core is idle; the core does not enforce this. Attack and release coefficients are Q0.24,
// the RMS coefficient is Q1.24, and the envelope output is unsigned Q1.23, clamped to 1.0.
module envelope_follower_attack_hold_release_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [efahr_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [efahr_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [efahr_pkg::SampleWidth-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [efahr_pkg::EnvW-1:0]             envelope_out_o
);
  import efahr_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQR  = 9'b000000010,
    ST_LVL  = 9'b000000100,
    ST_MSA  = 9'b000001000,
    ST_MSB  = 9'b000010000,
    ST_MSC  = 9'b000100000,
    ST_SQRT = 9'b001000000,
    ST_DIFF = 9'b010000000,
    ST_UPD  = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    UPD_RISE    = 2'd0,
    UPD_HOLD    = 2'd1,
    UPD_RELEASE = 2'd2
  } upd_e;

  state_e state_q, state_d;
  upd_e   upd_q, upd_d;

  // Configuration registers.
  logic [1:0]           mode_q;
  logic [CoeffW-1:0]    attack_q;
  logic [CoeffW-1:0]    release_q;
  logic [HoldWidth-1:0] hold_len_q;
  logic [RmsCoeffW-1:0] rms_coeff_q;

  // Persistent state.
  logic [EnvW-1:0]      env_q, env_d;
  logic [HoldWidth-1:0] hold_q, hold_d;
  logic [MsW-1:0]       ms_q, ms_d;

  // Per-sample working registers.
  logic [MagW-1:0]   mag_q, mag_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [ProdW-1:0]  acc_q, acc_d;
  logic [SqW-1:0]    sq_q, sq_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [EnvW-1:0]   out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Datapath helpers.
  logic [SampleWidth-1:0] abs_s;
  logic [MagW+MagShr-1:0] mag_wide;
  logic [MagW-1:0]        mag_in;
  logic [MulAW-1:0]       mul_a;
  logic [MulBW-1:0]       mul_b;
  logic [RmsCoeffW-1:0]   rms_c;
  logic [ProdW-1:0]       sq_sum;
  logic [ProdW-1:0]       lvl_sum;
  logic [ProdW-1:0]       ms_sum;
  logic [ProdW-1:0]       rnd_sum;
  logic [LevelW-1:0]      rnd;
  logic [LevelW-1:0]      env_ext;
  logic [LevelW-1:0]      env_new;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [RootW-1:0]       sqrt_root;
  logic                   in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Magnitude of the sample, aligned to Q5.23.
  always_comb begin
    abs_s    = sample_in_i[SampleWidth-1] ? (~sample_in_i + SampleWidth'(1)) : sample_in_i;
    mag_wide = (MagW + MagShr)'(abs_s) << MagShl;
    mag_in   = mag_wide[MagW+MagShr-1:MagShr];
  end

  // Averaging coefficient saturates at 1.0.
  assign rms_c = (rms_coeff_q > OneQ24) ? OneQ24 : rms_coeff_q;

  // Rounded views of the product register.
  always_comb begin
    sq_sum  = prod_q + HalfQ22;
    lvl_sum = prod_q + HalfQ23;
    ms_sum  = acc_q + prod_q + HalfQ24;
    rnd_sum = prod_q + HalfQ24;
    rnd     = rnd_sum[24 +: LevelW];
    env_ext = LevelW'(env_q);
  end

  // Shared multiplier operand selection. The envelope step product is kept
  // alive through the update step, so a stalled update still sees it.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQR: begin
        mul_a = MulAW'(mag_q);
        mul_b = MulBW'(mag_q);
      end
      ST_MSA: begin
        mul_a = MulAW'(ms_q);
        mul_b = MulBW'(OneQ24 - rms_c);
      end
      ST_MSB: begin
        mul_a = MulAW'(sq_q);
        mul_b = MulBW'(rms_c);
      end
      ST_DIFF, ST_UPD: begin
        if (level_q > env_ext) begin
          mul_a = MulAW'(level_q - env_ext);
          mul_b = MulBW'(attack_q);
        end else begin
          mul_a = MulAW'(env_ext - level_q);
          mul_b = MulBW'(release_q);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Envelope update for the chosen branch, before clamping.
  always_comb begin
    case (upd_q)
      UPD_RISE:    env_new = level_q - rnd;
      UPD_RELEASE: env_new = level_q + rnd;
      default:     env_new = env_ext;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    upd_d       = upd_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    level_d     = level_q;
    ms_d        = ms_q;
    env_d       = env_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sqrt_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mag_d   = mag_in;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        state_d = (mode_q == ModeRms) ? ST_MSA : ST_LVL;
      end
      ST_LVL: begin
        if (mode_q == ModeMeanSq) begin
          level_d = lvl_sum[23 +: LevelW];
        end else begin
          level_d = LevelW'(mag_q);
        end
        state_d = ST_DIFF;
      end
      ST_MSA: begin
        sq_d    = sq_sum[22 +: SqW];
        state_d = ST_MSB;
      end
      ST_MSB: begin
        acc_d   = prod_q;
        state_d = ST_MSC;
      end
      ST_MSC: begin
        ms_d       = ms_sum[24 +: MsW];
        sqrt_start = 1'b1;
        state_d    = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          level_d = LevelW'(sqrt_root);
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (level_q > env_ext) begin
          upd_d = UPD_RISE;
        end else if (hold_q != '0) begin
          upd_d = UPD_HOLD;
        end else begin
          upd_d = UPD_RELEASE;
        end
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // Wait here while the previous beat still sits in the output register.
        if (!out_valid_q || out_ready_i) begin
          if (upd_q == UPD_RISE) begin
            hold_d = hold_len_q;
          end else if (upd_q == UPD_HOLD) begin
            hold_d = hold_q - HoldWidth'(1);
          end
          if (env_new > LevelW'(OneQ23)) begin
            env_d = OneQ23;
          end else begin
            env_d = env_new[EnvW-1:0];
          end
          out_d       = env_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Square root of the running mean square, scaled to Q.23.
  efahr_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({ms_d, 22'b0}),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModePeak;
      attack_q    <= '0;
      release_q   <= '0;
      hold_len_q  <= '0;
      rms_coeff_q <= OneQ24;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DETECT_MODE:   mode_q      <= cfg_wdata_i[1:0];
        CFG_ATTACK_COEFF:  attack_q    <= cfg_wdata_i[CoeffW-1:0];
        CFG_RELEASE_COEFF: release_q   <= cfg_wdata_i[CoeffW-1:0];
        CFG_HOLD_LENGTH:   hold_len_q  <= cfg_wdata_i[HoldWidth-1:0];
        CFG_RMS_COEFF:     rms_coeff_q <= cfg_wdata_i[RmsCoeffW-1:0];
        default: ;
      endcase
    end
  end

  // Control and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upd_q       <= UPD_HOLD;
      env_q       <= '0;
      hold_q      <= '0;
      ms_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      upd_q       <= upd_d;
      env_q       <= env_d;
      hold_q      <= hold_d;
      ms_q        <= ms_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    level_q <= level_d;
    out_q   <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign envelope_out_o = out_q;

endmodule
